@@ rtl/core/aesp_pkg.sv @@
// shared constants and controller/datapath interface types for the escape sequence parser
package aesp_pkg;

    // default sizing
    localparam int ARGS_LIMIT_DEF = 16;
    localparam int SEQ_LIMIT_DEF  = 32;

    // control and special bytes
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_CSI   = 8'h5B;  // '['
    localparam logic [7:0] CH_OSC   = 8'h5D;  // ']'
    localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_QUEST = 8'h3F;  // '?'
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_BANG  = 8'h21;  // '!'
    localparam logic [7:0] CH_LT_M  = 8'h6D;  // 'm'
    localparam logic [7:0] CH_UP_J  = 8'h4A;  // 'J'
    localparam logic [7:0] CH_UP_K  = 8'h4B;  // 'K'
    localparam logic [7:0] CH_LPAR  = 8'h28;  // '('
    localparam logic [7:0] CH_RPAR  = 8'h29;  // ')'
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
    localparam logic [7:0] CH_SEVEN = 8'h37;  // '7'
    localparam logic [7:0] CH_EIGHT = 8'h38;  // '8'
    localparam logic [7:0] CH_UP_D  = 8'h44;  // 'D'
    localparam logic [7:0] CH_UP_M  = 8'h4D;  // 'M'

    // argument saturation value
    localparam logic [15:0] VALUE_MAX = 16'd59999;

    // result kinds
    localparam logic [1:0] KIND_CSI     = 2'd0;
    localparam logic [1:0] KIND_CHARSET = 2'd1;
    localparam logic [1:0] KIND_ESCAPE  = 2'd2;

    // private marker codes
    localparam logic [1:0] MARK_NONE  = 2'd0;
    localparam logic [1:0] MARK_QUEST = 2'd1;
    localparam logic [1:0] MARK_GT    = 2'd2;
    localparam logic [1:0] MARK_BANG  = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic take;         // input request accepted this cycle
        logic load_single;  // load a charset or single escape result
        logic load_arg;     // load the argument result read from the store
        logic next_idx;     // advance to the next argument
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic single_res;   // current byte completes a one-result sequence
        logic csi_final;    // current byte is a CSI final byte
        logic idx_last;     // argument index points at the last argument
    } t_dp_status;

endpackage

@@ rtl/core/aesp_ctrl.sv @@
// controller: input/output handshake and argument emission sequencing
module aesp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  aesp_pkg::t_dp_status i_status,
    output aesp_pkg::t_dp_cmd  o_cmd
);
    import aesp_pkg::*;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       take;

    // output register can accept a new result
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_RUN) || !out_free;
    assign take       = i_in_valid && !o_in_stall;

    // commands and next state
    always_comb begin
        o_cmd             = '0;
        o_cmd.take        = take;
        o_cmd.load_single = take && i_status.single_res;
        n_state           = r_state;
        case (r_state)
            ST_RUN: begin
                if (take && i_status.csi_final) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    o_cmd.load_arg = 1'b1;
                    if (i_status.idx_last) begin
                        n_state = ST_RUN;
                    end else begin
                        o_cmd.next_idx = 1'b1;
                        n_state        = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_single || o_cmd.load_arg) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/aesp_datapath.sv @@
// datapath: sequence tracking, argument accumulation, argument store and result register
module aesp_datapath #(
    parameter int ARGS_LIMIT = aesp_pkg::ARGS_LIMIT_DEF,
    parameter int SEQ_LIMIT  = aesp_pkg::SEQ_LIMIT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_in_byte,
    input  aesp_pkg::t_dp_cmd    i_cmd,
    output aesp_pkg::t_dp_status o_status,
    output logic [1:0]           o_kind,
    output logic [7:0]           o_final_byte,
    output logic [1:0]           o_private_marker,
    output logic                 o_charset_special,
    output logic [4:0]           o_arg_count,
    output logic [3:0]           o_arg_index,
    output logic [15:0]          o_arg_value,
    output logic                 o_last
);
    import aesp_pkg::*;

    localparam int IDX_W = (ARGS_LIMIT > 1) ? $clog2(ARGS_LIMIT) : 1;
    localparam int TOT_W = $clog2(ARGS_LIMIT + 2);
    localparam int LEN_W = $clog2(SEQ_LIMIT);
    localparam logic [TOT_W-1:0] TOT_LIMIT = TOT_W'(ARGS_LIMIT);
    localparam logic [LEN_W-1:0] LEN_STOP  = LEN_W'(SEQ_LIMIT - 1);

    typedef struct packed {
        logic        has;
        logic [15:0] val;
    } t_arg;

    // sequence state
    logic             r_active, n_active;
    logic [LEN_W-1:0] r_len, n_len;
    logic [7:0]       r_lead, n_lead;
    logic [1:0]       r_marker, n_marker;
    logic [TOT_W-1:0] r_tot, n_tot;
    logic [15:0]      r_cur, n_cur;
    logic             r_cur_has, n_cur_has;

    // emission state
    logic [TOT_W-1:0] r_cnt;
    logic [7:0]       r_fin;
    logic             r_dflt_one;
    logic [IDX_W-1:0] r_idx;
    t_arg             r_arg_mem [0:ARGS_LIMIT-1];
    t_arg             r_rd;

    // result register
    logic [1:0]  r_kind;
    logic [7:0]  r_final;
    logic [1:0]  r_mark_out;
    logic        r_cs;
    logic [4:0]  r_count;
    logic [3:0]  r_index;
    logic [15:0] r_value;
    logic        r_last;

    logic             is_esc, drop, live, first;
    logic [7:0]       lead;
    logic             lead_csi, lead_osc, lead_cs, lead_single;
    logic             dec_char, is_marker;
    logic             csi_open, csi_marker, csi_body, csi_digit, csi_semi, csi_fin;
    logic             cs_res, esc_res, osc_end, unknown;
    logic             in_range, commit;
    logic [TOT_W-1:0] tot_m1, cnt_m1;
    logic [IDX_W-1:0] slot, last_idx;
    logic [19:0]      cur_ext, prod;
    logic [15:0]      digit_val;
    logic [1:0]       marker_code;

    // byte decode against the sequence state
    assign is_esc    = (i_in_byte == CH_ESC);
    assign drop      = r_active && (r_len >= LEN_STOP);
    assign live      = r_active && !is_esc && !drop;
    assign first     = (r_len == '0);
    assign lead      = first ? i_in_byte : r_lead;
    assign lead_csi  = (lead == CH_CSI);
    assign lead_osc  = (lead == CH_OSC);
    assign lead_cs   = lead inside {CH_LPAR, CH_RPAR, CH_STAR, CH_PLUS,
                                    CH_MINUS, CH_DOT, CH_SLASH};
    assign lead_single = lead inside {CH_EQ, CH_GT, CH_SEVEN, CH_EIGHT, CH_UP_D, CH_UP_M};
    assign dec_char  = i_in_byte inside {[CH_ZERO:CH_NINE]};
    assign is_marker = i_in_byte inside {CH_QUEST, CH_GT, CH_BANG};

    assign csi_open   = live && lead_csi && first;
    assign csi_marker = live && lead_csi && (r_len == LEN_W'(1)) && is_marker;
    assign csi_body   = live && lead_csi && !first && !csi_marker;
    assign csi_digit  = csi_body && dec_char;
    assign csi_semi   = csi_body && (i_in_byte == CH_SEMI);
    assign csi_fin    = csi_body && !dec_char && (i_in_byte != CH_SEMI);
    assign cs_res     = live && lead_cs && !first;
    assign esc_res    = live && lead_single;
    assign osc_end    = live && lead_osc && (i_in_byte == CH_BEL);
    assign unknown    = live && !lead_csi && !lead_osc && !lead_cs && !lead_single;

    // argument slot bookkeeping
    assign in_range = (r_tot <= TOT_LIMIT);
    assign commit   = (csi_semi || csi_fin) && in_range;
    assign tot_m1   = r_tot - TOT_W'(1);
    assign slot     = tot_m1[IDX_W-1:0];
    assign cnt_m1   = r_cnt - TOT_W'(1);
    assign last_idx = cnt_m1[IDX_W-1:0];

    // decimal accumulate with saturation
    assign cur_ext   = {4'b0, r_cur};
    assign prod      = (cur_ext << 3) + (cur_ext << 1) + {16'b0, i_in_byte[3:0]};
    assign digit_val = (prod > {4'b0, VALUE_MAX}) ? VALUE_MAX : prod[15:0];

    always_comb begin
        case (i_in_byte)
            CH_QUEST: marker_code = MARK_QUEST;
            CH_GT:    marker_code = MARK_GT;
            CH_BANG:  marker_code = MARK_BANG;
            default:  marker_code = MARK_NONE;
        endcase
    end

    // sequence next state
    always_comb begin
        n_active  = r_active;
        n_len     = r_len;
        n_lead    = r_lead;
        n_marker  = r_marker;
        n_tot     = r_tot;
        n_cur     = r_cur;
        n_cur_has = r_cur_has;
        if (is_esc) begin
            n_active = 1'b1;
            n_len    = '0;
            n_marker = MARK_NONE;
            n_tot    = '0;
        end else if (drop) begin
            n_active = 1'b0;
        end else if (live) begin
            n_len = r_len + LEN_W'(1);
            if (first) begin
                n_lead = i_in_byte;
            end
            if (csi_open) begin
                n_tot     = TOT_W'(1);
                n_cur     = '0;
                n_cur_has = 1'b0;
            end
            if (csi_marker) begin
                n_marker = marker_code;
            end
            if (csi_digit && in_range) begin
                n_cur     = digit_val;
                n_cur_has = 1'b1;
            end
            if (csi_semi && in_range) begin
                n_tot     = r_tot + TOT_W'(1);
                n_cur     = '0;
                n_cur_has = 1'b0;
            end
            if (csi_fin || cs_res || esc_res || osc_end || unknown) begin
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_len     <= '0;
            r_lead    <= '0;
            r_marker  <= MARK_NONE;
            r_tot     <= '0;
            r_cur     <= '0;
            r_cur_has <= 1'b0;
        end else if (i_cmd.take) begin
            r_active  <= n_active;
            r_len     <= n_len;
            r_lead    <= n_lead;
            r_marker  <= n_marker;
            r_tot     <= n_tot;
            r_cur     <= n_cur;
            r_cur_has <= n_cur_has;
        end
    end

    // argument store: write on close of an argument, read at the emit index
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && commit) begin
            r_arg_mem[slot] <= '{has: r_cur_has, val: r_cur};
        end
        r_rd <= r_arg_mem[r_idx];
    end

    // capture the CSI command and walk the arguments
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.take && csi_fin) begin
            r_idx <= '0;
        end else if (i_cmd.next_idx) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && csi_fin) begin
            r_fin      <= i_in_byte;
            r_dflt_one <= !(i_in_byte inside {CH_LT_M, CH_UP_J, CH_UP_K});
            r_cnt      <= in_range ? r_tot : TOT_LIMIT;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_single) begin
            r_kind     <= cs_res ? KIND_CHARSET : KIND_ESCAPE;
            r_final    <= cs_res ? i_in_byte : lead;
            r_mark_out <= MARK_NONE;
            r_cs       <= cs_res && (i_in_byte == CH_ZERO);
            r_count    <= '0;
            r_index    <= '0;
            r_value    <= '0;
            r_last     <= 1'b1;
        end else if (i_cmd.load_arg) begin
            r_kind     <= KIND_CSI;
            r_final    <= r_fin;
            r_mark_out <= r_marker;
            r_cs       <= 1'b0;
            r_count    <= 5'(r_cnt);
            r_index    <= 4'(r_idx);
            r_value    <= r_rd.has ? r_rd.val : {15'b0, r_dflt_one};
            r_last     <= (r_idx == last_idx);
        end
    end

    assign o_status.single_res = cs_res || esc_res;
    assign o_status.csi_final  = csi_fin;
    assign o_status.idx_last   = (r_idx == last_idx);

    assign o_kind            = r_kind;
    assign o_final_byte      = r_final;
    assign o_private_marker  = r_mark_out;
    assign o_charset_special = r_cs;
    assign o_arg_count       = r_count;
    assign o_arg_index       = r_index;
    assign o_arg_value       = r_value;
    assign o_last            = r_last;

endmodule

@@ rtl/core/ansi_escape_sequence_parser.sv @@
// top level of the terminal escape sequence parser
// Usage:
//   Input channel: one terminal byte per request on i_in_byte, taken when
//   i_in_valid is high and o_in_stall is low. Bytes outside a sequence are
//   dropped; ESC always (re)starts a sequence.
//   Output channel: one result per request, held in an output register and
//   taken when o_out_valid is high and i_out_stall is low; o_last marks the
//   final result of a sequence.
//   Throughput: one byte per cycle while no argument emission is in progress
//   and the output register is free or being drained. A charset or single
//   escape result appears in the cycle after its byte is taken. A CSI final
//   byte starts argument emission: each argument is first read from the
//   argument store and then loaded into the output register, and the input
//   is stalled until the last argument of the sequence has been loaded.
//   When the receiver stalls, the pending result holds and the input is
//   stalled for as long as a result waits in the output register.
//   Reset (synchronous, active low) returns to outside-sequence state with an
//   empty output register; the argument store needs no clearing.
module ansi_escape_sequence_parser #(
    parameter int ARGS_LIMIT = aesp_pkg::ARGS_LIMIT_DEF,
    parameter int SEQ_LIMIT  = aesp_pkg::SEQ_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_final_byte,
    output logic [1:0]  o_private_marker,
    output logic        o_charset_special,
    output logic [4:0]  o_arg_count,
    output logic [3:0]  o_arg_index,
    output logic [15:0] o_arg_value,
    output logic        o_last
);
    import aesp_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // handshake and sequencing
    aesp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // parsing state, argument store and result register
    aesp_datapath #(
        .ARGS_LIMIT (ARGS_LIMIT),
        .SEQ_LIMIT  (SEQ_LIMIT)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_byte         (i_in_byte),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_kind            (o_kind),
        .o_final_byte      (o_final_byte),
        .o_private_marker  (o_private_marker),
        .o_charset_special (o_charset_special),
        .o_arg_count       (o_arg_count),
        .o_arg_index       (o_arg_index),
        .o_arg_value       (o_arg_value),
        .o_last            (o_last)
    );

endmodule
